>>> rtl/clst_pkg.sv
// Shared types and constants of the CAN light status table.
`default_nettype none

package clst_pkg;

	localparam int ID_W       = 29;
	localparam int TIME_W     = 32;
	localparam int BYTE_W     = 8;
	localparam int COLOR_W    = 24;
	localparam int LEN_W      = 4;
	localparam int OP_W       = 2;
	localparam int QIDX_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int KIND_W     = 3;

	// Operation codes on the input port.
	localparam logic [OP_W-1:0] OP_FRAME  = 2'd0;
	localparam logic [OP_W-1:0] OP_QSTRIP = 2'd1;
	localparam logic [OP_W-1:0] OP_QPARK  = 2'd2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_ID  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRIP_BASE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PARK_MASK  = 3'd3;

	// Register reset values.
	localparam logic [ID_W-1:0]   RST_SIGNAL_ID  = 29'd1312;
	localparam logic [ID_W-1:0]   RST_STRIP_BASE = 29'd1280;
	localparam logic [TIME_W-1:0] RST_TIMEOUT    = 32'd1000;
	localparam logic [BYTE_W-1:0] RST_PARK_MASK  = 8'd1;

	// Command kinds produced by the classifier.
	localparam logic [KIND_W-1:0] KIND_NOP    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SIGNAL = 3'd1;
	localparam logic [KIND_W-1:0] KIND_STRIP  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_QSTRIP = 3'd3;
	localparam logic [KIND_W-1:0] KIND_QPARK  = 3'd4;

	typedef struct packed {
		logic [ID_W-1:0]   signal_frame_id;
		logic [ID_W-1:0]   strip_base_id;
		logic [TIME_W-1:0] offline_timeout;
		logic [BYTE_W-1:0] park_mask;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] byte_zero;
		logic [BYTE_W-1:0] byte_one;
		logic [BYTE_W-1:0] byte_two;
		logic [BYTE_W-1:0] byte_three;
		logic [TIME_W-1:0] time_ms;
	} cmd_t;

endpackage

`default_nettype wire

>>> rtl/can_light_status_table_unit.sv
// Top level of the CAN light status table: configuration registers and the two halves.
//
//   Channel   Handshake          Payload
//   input     start / busy       operation, frame_id, data_length, byte_zero..byte_three,
//                                strip_index, time_ms
//   result    done (strobe)      frame_taken, strip_online, strip_color, park_on
//   config    cfg_we             cfg_index, cfg_data
//
// One input beat can be taken every cycle while busy is low. Its result beat passes
// through an entry of the command queue; then the RAM read, the scale multiplies and
// the divide by 255 each take one registered stage.
// Reset clears the signal store, the strip seen bits and the pipeline; a strip whose
// seen bit is clear reads as never seen. The receiver cannot stall, so the engine
// drains the queue every cycle and busy only rises if the queue fills.
`default_nettype none

module can_light_status_table_unit #(
	parameter int STRIP_COUNT = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [clst_pkg::OP_W-1:0]       operation,
	input  wire logic [clst_pkg::ID_W-1:0]       frame_id,
	input  wire logic [clst_pkg::LEN_W-1:0]      data_length,
	input  wire logic [clst_pkg::BYTE_W-1:0]     byte_zero,
	input  wire logic [clst_pkg::BYTE_W-1:0]     byte_one,
	input  wire logic [clst_pkg::BYTE_W-1:0]     byte_two,
	input  wire logic [clst_pkg::BYTE_W-1:0]     byte_three,
	input  wire logic [clst_pkg::QIDX_W-1:0]     strip_index,
	input  wire logic [clst_pkg::TIME_W-1:0]     time_ms,
	output logic                                 done,
	output logic                                 frame_taken,
	output logic                                 strip_online,
	output logic      [clst_pkg::COLOR_W-1:0]    strip_color,
	output logic                                 park_on,
	input  wire logic                            cfg_we,
	input  wire logic [clst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [clst_pkg::CFG_DATA_W-1:0] cfg_data
);

	import clst_pkg::*;

	localparam int IDX_W  = (STRIP_COUNT > 1) ? $clog2(STRIP_COUNT) : 1;
	localparam int QENT_W = $bits(cmd_t) + IDX_W;

	cfg_t              cfg_q;
	logic              queue_full;
	logic              queue_empty;
	logic              push;
	logic              pop;
	cmd_t              push_cmd;
	logic [IDX_W-1:0]  push_index;
	cmd_t              head_cmd;
	logic [IDX_W-1:0]  head_index;
	logic [QENT_W-1:0] head_entry;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.signal_frame_id <= RST_SIGNAL_ID;
			cfg_q.strip_base_id   <= RST_STRIP_BASE;
			cfg_q.offline_timeout <= RST_TIMEOUT;
			cfg_q.park_mask       <= RST_PARK_MASK;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIGNAL_ID:  cfg_q.signal_frame_id <= cfg_data[ID_W-1:0];
				REG_STRIP_BASE: cfg_q.strip_base_id   <= cfg_data[ID_W-1:0];
				REG_TIMEOUT:    cfg_q.offline_timeout <= cfg_data[TIME_W-1:0];
				REG_PARK_MASK:  cfg_q.park_mask       <= cfg_data[BYTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Classifier.
	clst_front #(
		.STRIP_COUNT (STRIP_COUNT)
	) u_front (
		.start       (start),
		.queue_full  (queue_full),
		.operation   (operation),
		.frame_id    (frame_id),
		.data_length (data_length),
		.byte_zero   (byte_zero),
		.byte_one    (byte_one),
		.byte_two    (byte_two),
		.byte_three  (byte_three),
		.strip_index (strip_index),
		.time_ms     (time_ms),
		.cfg         (cfg_q),
		.busy        (busy),
		.push        (push),
		.push_cmd    (push_cmd),
		.push_index  (push_index)
	);

	// Command queue.
	clst_fifo #(
		.WIDTH (QENT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_cmd, push_index}),
		.pop       (pop),
		.pop_data  (head_entry),
		.empty     (queue_empty),
		.full      (queue_full)
	);

	assign {head_cmd, head_index} = head_entry;

	// Table engine.
	clst_back #(
		.STRIP_COUNT (STRIP_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.queue_empty  (queue_empty),
		.cmd          (head_cmd),
		.cmd_index    (head_index),
		.pop          (pop),
		.done         (done),
		.frame_taken  (frame_taken),
		.strip_online (strip_online),
		.strip_color  (strip_color),
		.park_on      (park_on)
	);

	// Every accepted beat yields its result beat.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("result beat missing after accepted input beat");

	// A result answers one kind of operation only.
	a_one_answer: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($countones({frame_taken, strip_online, park_on}) <= 1))
		else $error("result beat carries more than one answer");

	// An offline strip reports no color.
	a_dark_offline: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !strip_online) |-> (strip_color == '0))
		else $error("color reported for an offline strip");

endmodule

`default_nettype wire

>>> rtl/clst_ram.sv
// Generic single write port RAM with a registered read port.
`default_nettype none

module clst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, then registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/clst_fifo.sv
// Two entry command queue between the classifier and the table engine.
`default_nettype none

module clst_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data,
	output logic                  empty,
	output logic                  full
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign empty    = (count_q == 2'd0);
	assign full     = (count_q == 2'd2);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

>>> rtl/clst_front.sv
// Front end: accepts input beats and classifies them into table commands.
`default_nettype none

module clst_front #(
	parameter int STRIP_COUNT = 8,
	localparam int IDX_W = (STRIP_COUNT > 1) ? $clog2(STRIP_COUNT) : 1
) (
	input  wire logic                          start,
	input  wire logic                          queue_full,
	input  wire logic [clst_pkg::OP_W-1:0]     operation,
	input  wire logic [clst_pkg::ID_W-1:0]     frame_id,
	input  wire logic [clst_pkg::LEN_W-1:0]    data_length,
	input  wire logic [clst_pkg::BYTE_W-1:0]   byte_zero,
	input  wire logic [clst_pkg::BYTE_W-1:0]   byte_one,
	input  wire logic [clst_pkg::BYTE_W-1:0]   byte_two,
	input  wire logic [clst_pkg::BYTE_W-1:0]   byte_three,
	input  wire logic [clst_pkg::QIDX_W-1:0]   strip_index,
	input  wire logic [clst_pkg::TIME_W-1:0]   time_ms,
	input  wire clst_pkg::cfg_t                cfg,
	output logic                               busy,
	output logic                               push,
	output clst_pkg::cmd_t                     push_cmd,
	output logic      [IDX_W-1:0]              push_index
);

	import clst_pkg::*;

	logic [ID_W-1:0] id_offset;
	logic            strip_hit;
	logic            query_ok;
	logic [6:0]      query_wide;

	assign busy = queue_full;
	assign push = start && !queue_full;

	// Strip window match on the frame identifier.
	assign id_offset  = frame_id - cfg.strip_base_id;
	assign strip_hit  = (frame_id >= cfg.strip_base_id) &&
	                    (id_offset < ID_W'(STRIP_COUNT));
	assign query_wide = 7'(strip_index);
	assign query_ok   = query_wide < 7'(STRIP_COUNT);

	// Command decode; the signals frame wins when both identifiers match.
	always_comb begin
		push_cmd.kind       = KIND_NOP;
		push_cmd.byte_zero  = byte_zero;
		push_cmd.byte_one   = byte_one;
		push_cmd.byte_two   = byte_two;
		push_cmd.byte_three = byte_three;
		push_cmd.time_ms    = time_ms;
		push_index          = query_wide[IDX_W-1:0];
		unique case (operation)
			OP_FRAME: begin
				if (frame_id == cfg.signal_frame_id) begin
					push_cmd.kind = KIND_SIGNAL;
					if (data_length == '0) begin
						push_cmd.byte_zero = '0;
					end
				end else if (strip_hit) begin
					push_cmd.kind = KIND_STRIP;
					push_index    = id_offset[IDX_W-1:0];
				end
			end
			OP_QSTRIP: begin
				if (query_ok) begin
					push_cmd.kind = KIND_QSTRIP;
				end
			end
			OP_QPARK: begin
				push_cmd.kind = KIND_QPARK;
			end
			default: begin
				push_cmd.kind = KIND_NOP;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/clst_back.sv
// Back end: updates the status table and answers queries in three stages.
`default_nettype none

module clst_back #(
	parameter int STRIP_COUNT = 8,
	localparam int IDX_W = (STRIP_COUNT > 1) ? $clog2(STRIP_COUNT) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire clst_pkg::cfg_t                cfg,
	input  wire logic                          queue_empty,
	input  wire clst_pkg::cmd_t                cmd,
	input  wire logic [IDX_W-1:0]              cmd_index,
	output logic                               pop,
	output logic                               done,
	output logic                               frame_taken,
	output logic                               strip_online,
	output logic      [clst_pkg::COLOR_W-1:0]  strip_color,
	output logic                               park_on
);

	import clst_pkg::*;

	localparam int ENTRY_W = 4 * BYTE_W + TIME_W;

	// Exact division by 255 of a product of two bytes.
	function automatic logic [BYTE_W-1:0] div255(input logic [2*BYTE_W-1:0] p);
		logic [2*BYTE_W:0] sum;
		sum = (2*BYTE_W+1)'(p) + (2*BYTE_W+1)'(p[2*BYTE_W-1:BYTE_W]) + 17'd1;
		return sum[2*BYTE_W-1:BYTE_W];
	endfunction

	// Table state outside the RAM.
	logic [STRIP_COUNT-1:0] seen_q;
	logic [BYTE_W-1:0]      lighting_q;
	logic [TIME_W-1:0]      signal_stamp_q;

	logic                   item;
	logic                   strip_write;
	logic [TIME_W-1:0]      signal_age;
	logic                   park_now;
	logic [ENTRY_W-1:0]     wr_entry;
	logic [ENTRY_W-1:0]     rd_entry;

	// Stage 1.
	logic                   valid_s1;
	logic [KIND_W-1:0]      kind_s1;
	logic [TIME_W-1:0]      time_s1;
	logic                   seen_s1;
	logic                   park_s1;

	// Stage 2.
	logic                   valid_s2;
	logic [KIND_W-1:0]      kind_s2;
	logic                   online_s2;
	logic                   park_s2;
	logic [2*BYTE_W-1:0]    prod_r_s2;
	logic [2*BYTE_W-1:0]    prod_g_s2;
	logic [2*BYTE_W-1:0]    prod_b_s2;

	logic [BYTE_W-1:0]      rd_red;
	logic [BYTE_W-1:0]      rd_green;
	logic [BYTE_W-1:0]      rd_blue;
	logic [BYTE_W-1:0]      rd_scale;
	logic [TIME_W-1:0]      rd_stamp;
	logic [TIME_W-1:0]      strip_age;
	logic                   online_now;

	// Output registers.
	logic                   done_q;
	logic                   taken_q;
	logic                   online_q;
	logic [COLOR_W-1:0]     color_q;
	logic                   park_q;

	// The engine takes one command per cycle whenever the queue holds one.
	assign item        = !queue_empty;
	assign pop         = item;
	assign strip_write = item && (cmd.kind == KIND_STRIP);
	assign wr_entry    = {cmd.byte_zero, cmd.byte_one, cmd.byte_two, cmd.byte_three,
	                      cmd.time_ms};

	clst_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STRIP_COUNT)
	) u_strip_ram (
		.clk   (clk),
		.we    (strip_write),
		.waddr (cmd_index),
		.wdata (wr_entry),
		.raddr (cmd_index),
		.rdata (rd_entry)
	);

	// Park check against the signal source as it stands.
	assign signal_age = cmd.time_ms - signal_stamp_q;
	assign park_now   = (signal_stamp_q != '0) && (signal_age < cfg.offline_timeout) &&
	                    ((lighting_q & cfg.park_mask) != '0);

	// Signal store and strip seen bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q         <= '0;
			lighting_q     <= '0;
			signal_stamp_q <= '0;
		end else begin
			if (strip_write) begin
				seen_q[cmd_index] <= 1'b1;
			end
			if (item && (cmd.kind == KIND_SIGNAL)) begin
				lighting_q     <= cmd.byte_zero;
				signal_stamp_q <= cmd.time_ms;
			end
		end
	end

	// Stage 1 registers, alongside the RAM read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= item;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= cmd.kind;
		time_s1 <= cmd.time_ms;
		seen_s1 <= seen_q[cmd_index];
		park_s1 <= (cmd.kind == KIND_QPARK) && park_now;
	end

	// Freshness of the queried strip.
	assign {rd_red, rd_green, rd_blue, rd_scale, rd_stamp} = rd_entry;
	assign strip_age  = time_s1 - rd_stamp;
	assign online_now = (kind_s1 == KIND_QSTRIP) && seen_s1 && (rd_stamp != '0) &&
	                    (strip_age < cfg.offline_timeout);

	// Stage 2 registers: scale products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s2   <= kind_s1;
		online_s2 <= online_now;
		park_s2   <= park_s1;
		prod_r_s2 <= (2*BYTE_W)'(rd_red) * (2*BYTE_W)'(rd_scale);
		prod_g_s2 <= (2*BYTE_W)'(rd_green) * (2*BYTE_W)'(rd_scale);
		prod_b_s2 <= (2*BYTE_W)'(rd_blue) * (2*BYTE_W)'(rd_scale);
	end

	// Result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		taken_q  <= (kind_s2 == KIND_SIGNAL) || (kind_s2 == KIND_STRIP);
		online_q <= online_s2;
		park_q   <= park_s2;
		if (online_s2) begin
			color_q <= {div255(prod_r_s2), div255(prod_g_s2), div255(prod_b_s2)};
		end else begin
			color_q <= '0;
		end
	end

	assign done         = done_q;
	assign frame_taken  = taken_q;
	assign strip_online = online_q;
	assign strip_color  = color_q;
	assign park_on      = park_q;

endmodule

`default_nettype wire

>>> verif/tb_can_light_status_table_unit.sv
// Self-checking testbench of the CAN light status table unit: directed and random traffic.

module tb_can_light_status_table_unit;
	import clst_pkg::*;

	localparam int PERIOD       = 20;
	localparam int STRIPS       = 8;
	localparam int RESET_CYCLES = 6;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES       = 6;
	localparam int PHASE_BEATS  = 320;
	localparam int IDLE_PCT     = 16;

	// The operation code that the block must ignore.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [ID_W-1:0] ID_MAX    = '1;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ID_W-1:0]   id;
		logic [LEN_W-1:0]  len;
		logic [BYTE_W-1:0] b0;
		logic [BYTE_W-1:0] b1;
		logic [BYTE_W-1:0] b2;
		logic [BYTE_W-1:0] b3;
		logic [QIDX_W-1:0] sidx;
		logic [TIME_W-1:0] now;
	} request_t;

	typedef struct packed {
		logic               taken;
		logic               online;
		logic [COLOR_W-1:0] color;
		logic               park;
	} status_t;

	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  start       = 1'b0;
	logic [OP_W-1:0]       operation   = '0;
	logic [ID_W-1:0]       frame_id    = '0;
	logic [LEN_W-1:0]      data_length = '0;
	logic [BYTE_W-1:0]     byte_zero   = '0;
	logic [BYTE_W-1:0]     byte_one    = '0;
	logic [BYTE_W-1:0]     byte_two    = '0;
	logic [BYTE_W-1:0]     byte_three  = '0;
	logic [QIDX_W-1:0]     strip_index = '0;
	logic [TIME_W-1:0]     time_ms     = '0;
	logic                  cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  busy;
	logic                  done;
	logic                  frame_taken;
	logic                  strip_online;
	logic [COLOR_W-1:0]    strip_color;
	logic                  park_on;

	can_light_status_table_unit #(
		.STRIP_COUNT(STRIPS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.frame_id    (frame_id),
		.data_length (data_length),
		.byte_zero   (byte_zero),
		.byte_one    (byte_one),
		.byte_two    (byte_two),
		.byte_three  (byte_three),
		.strip_index (strip_index),
		.time_ms     (time_ms),
		.done        (done),
		.frame_taken (frame_taken),
		.strip_online(strip_online),
		.strip_color (strip_color),
		.park_on     (park_on),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Our own copy of the status table and of the registers.
	logic [BYTE_W-1:0] red_tbl   [STRIPS];
	logic [BYTE_W-1:0] green_tbl [STRIPS];
	logic [BYTE_W-1:0] blue_tbl  [STRIPS];
	logic [BYTE_W-1:0] scale_tbl [STRIPS];
	logic [TIME_W-1:0] stamp_tbl [STRIPS];
	logic [BYTE_W-1:0] light_byte;
	logic [TIME_W-1:0] light_stamp;
	cfg_t              cfg_now;

	status_t           pending_status_q[$];
	logic [TIME_W-1:0] clock_ms;
	int                idle_pct        = IDLE_PCT;
	int                error_count     = 0;
	int                beats_sent      = 0;
	int                results_checked = 0;
	int                settings_used   = 0;
	int                quiet_cycles    = 0;

	initial begin
		clk = 1'b0;
		forever #(PERIOD / 2) clk = ~clk;
	end

	// A source is live once stamped with a nonzero time and younger than the timeout.
	function automatic logic is_live(input logic [TIME_W-1:0] stamp, input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] age;
		age = now - stamp;
		return (stamp != '0) && (age < cfg_now.offline_timeout);
	endfunction

	// One color channel scaled by brightness, truncated.
	function automatic logic [BYTE_W-1:0] dim_channel(input logic [BYTE_W-1:0] chan,
			input logic [BYTE_W-1:0] bright);
		logic [15:0] prod;
		prod = 16'(chan) * 16'(bright);
		return BYTE_W'(prod / 16'd255);
	endfunction

	// Applies one request to the table copy and returns the status it should produce.
	function automatic status_t update_table(input request_t r);
		status_t           res;
		logic [31:0]       offset;
		int                k;
		logic [BYTE_W-1:0] bright;
		res = '0;
		offset = 32'(r.id) - 32'(cfg_now.strip_base_id);
		case (r.op)
			OP_FRAME: begin
				// The signals frame wins when an identifier has both roles.
				if (r.id == cfg_now.signal_frame_id) begin
					light_byte = (r.len != '0) ? r.b0 : '0;
					light_stamp = r.now;
					res.taken = 1'b1;
				end else if (r.id >= cfg_now.strip_base_id && offset < STRIPS) begin
					k = int'(offset);
					red_tbl[k] = r.b0;
					green_tbl[k] = r.b1;
					blue_tbl[k] = r.b2;
					scale_tbl[k] = r.b3;
					stamp_tbl[k] = r.now;
					res.taken = 1'b1;
				end
			end
			OP_QSTRIP: begin
				if (is_live(stamp_tbl[r.sidx], r.now)) begin
					bright = scale_tbl[r.sidx];
					res.online = 1'b1;
					res.color = {dim_channel(red_tbl[r.sidx], bright),
						dim_channel(green_tbl[r.sidx], bright),
						dim_channel(blue_tbl[r.sidx], bright)};
				end
			end
			OP_QPARK: begin
				res.park = is_live(light_stamp, r.now) && ((light_byte & cfg_now.park_mask) != '0);
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// Every field random; callers overwrite the ones that matter.
	function automatic request_t random_request();
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		return raw[$bits(request_t)-1:0];
	endfunction

	function automatic request_t frame_req(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
			input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
			input logic [BYTE_W-1:0] b2, input logic [BYTE_W-1:0] b3,
			input logic [TIME_W-1:0] now);
		request_t r;
		r = random_request();
		r.op = OP_FRAME;
		r.id = id;
		r.len = len;
		r.b0 = b0;
		r.b1 = b1;
		r.b2 = b2;
		r.b3 = b3;
		r.now = now;
		return r;
	endfunction

	function automatic request_t strip_query(input logic [QIDX_W-1:0] sidx,
			input logic [TIME_W-1:0] now);
		request_t r;
		r = random_request();
		r.op = OP_QSTRIP;
		r.sidx = sidx;
		r.now = now;
		return r;
	endfunction

	function automatic request_t park_query(input logic [TIME_W-1:0] now);
		request_t r;
		r = random_request();
		r.op = OP_QPARK;
		r.now = now;
		return r;
	endfunction

	// Data bytes lean toward the extremes.
	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return BYTE_W'($urandom);
		endcase
	endfunction

	// Mostly well-formed traffic on a moving clock, with some noise and boundary times.
	function automatic request_t next_traffic();
		request_t    r;
		int          pick;
		int unsigned step_max;
		logic [31:0] target;
		logic [31:0] tmo;
		r = random_request();
		tmo = cfg_now.offline_timeout;
		if (tmo == 0)
			step_max = 200;
		else if (tmo <= 64)
			step_max = 2 * tmo;
		else if (tmo < 32'h0100_0000)
			step_max = tmo / 3;
		else
			step_max = 5000;
		clock_ms = clock_ms + $urandom_range(0, step_max);
		r.now = clock_ms;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			// Strip frame, usually full length.
			r.op = OP_FRAME;
			target = 32'(cfg_now.strip_base_id) + $urandom_range(0, STRIPS - 1);
			r.id = (target <= 32'(ID_MAX)) ? target[ID_W-1:0] : cfg_now.strip_base_id;
			r.len = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(0, 15)) : 4'd8;
			r.b0 = pick_byte();
			r.b1 = pick_byte();
			r.b2 = pick_byte();
			r.b3 = pick_byte();
		end else if (pick < 45) begin
			// Signals frame.
			r.op = OP_FRAME;
			r.id = cfg_now.signal_frame_id;
			r.len = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(0, 15))
				: LEN_W'($urandom_range(1, 8));
			r.b0 = pick_byte();
		end else if (pick < 70) begin
			// Strip query, sometimes right at the edge of the timeout.
			r.op = OP_QSTRIP;
			if ($urandom_range(0, 4) == 0)
				r.now = stamp_tbl[r.sidx] + tmo - $urandom_range(0, 1);
		end else if (pick < 85) begin
			r.op = OP_QPARK;
			if ($urandom_range(0, 4) == 0)
				r.now = light_stamp + tmo - $urandom_range(0, 1);
		end else if (pick < 95) begin
			// Frames that should be rejected, or random identifiers.
			r.op = OP_FRAME;
			case ($urandom_range(0, 2))
				0: r.id = cfg_now.strip_base_id - 1'b1;
				1: r.id = cfg_now.strip_base_id + ID_W'(STRIPS);
				default: begin
				end
			endcase
		end else if (pick < 98) begin
			r.op = OP_UNUSED;
		end else begin
			// Jump anywhere in time with whatever operation came up.
			r.now = $urandom;
		end
		if (r.op == OP_FRAME && $urandom_range(0, 32) == 0)
			r.now = '0;
		return r;
	endfunction

	// Sends one request beat and records the status it should produce.
	task automatic send_request(input request_t r);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= r.op;
		frame_id <= r.id;
		data_length <= r.len;
		byte_zero <= r.b0;
		byte_one <= r.b1;
		byte_two <= r.b2;
		byte_three <= r.b3;
		strip_index <= r.sidx;
		time_ms <= r.now;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_status_q.push_back(update_table(r));
		beats_sent++;
	endtask

	// Waits until every expected result has come back and the pipeline is empty.
	task automatic drain_pipeline();
		start <= 1'b0;
		while (pending_status_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SIGNAL_ID: cfg_now.signal_frame_id = data[ID_W-1:0];
			REG_STRIP_BASE: cfg_now.strip_base_id = data[ID_W-1:0];
			REG_TIMEOUT: cfg_now.offline_timeout = data[TIME_W-1:0];
			REG_PARK_MASK: cfg_now.park_mask = data[BYTE_W-1:0];
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	// Writes all four registers once the block is idle.
	task automatic set_registers(input logic [31:0] sig, input logic [31:0] base,
			input logic [31:0] tmo, input logic [31:0] mask);
		drain_pipeline();
		write_reg(REG_SIGNAL_ID, sig);
		write_reg(REG_STRIP_BASE, base);
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_PARK_MASK, mask);
		settings_used++;
	endtask

	// Special cases under the reset register values.
	task automatic test_directed_cases();
		// Nothing seen yet, and the unused operation.
		send_request(strip_query(3'd0, 32'd5));
		send_request(park_query(32'd5));
		send_request('1);
		// Signals frame, then park right before and at the timeout.
		send_request(frame_req(RST_SIGNAL_ID, 4'd1, 8'h01, 8'h00, 8'h00, 8'h00, 32'd100));
		send_request(park_query(32'd1099));
		send_request(park_query(32'd1100));
		// A zero length signals frame clears the lighting byte.
		send_request(frame_req(RST_SIGNAL_ID, 4'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'd1200));
		send_request(park_query(32'd1201));
		// Length codes above eight count as nonzero; a query older than the stamp is stale.
		send_request(frame_req(RST_SIGNAL_ID, 4'd15, 8'hFF, 8'h00, 8'h00, 8'h00, 32'd1300));
		send_request(park_query(32'd1300));
		send_request(park_query(32'd1299));
		// Full-scale and zero-brightness strips; a short frame still stores all bytes.
		send_request(frame_req(RST_STRIP_BASE, 4'd8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'd2000));
		send_request(strip_query(3'd0, 32'd2000));
		send_request(frame_req(RST_STRIP_BASE + 29'd7, 4'd2, 8'hFF, 8'h80, 8'h01, 8'h00,
			32'd2100));
		send_request(strip_query(3'd7, 32'd2500));
		send_request(frame_req(RST_STRIP_BASE + 29'd3, 4'd0, 8'hFF, 8'h7F, 8'h00, 8'h80,
			32'd3000));
		send_request(strip_query(3'd3, 32'd3001));
		// A frame at time zero stores data but the strip still reads as offline.
		send_request(frame_req(RST_STRIP_BASE + 29'd1, 4'd8, 8'h10, 8'h20, 8'h30, 8'hFF, 32'd0));
		send_request(strip_query(3'd1, 32'd0));
		send_request(strip_query(3'd1, 32'd5));
		// Identifiers just outside the strip range and the largest one are rejected.
		send_request(frame_req(RST_STRIP_BASE + 29'd8, 4'd8, 8'h11, 8'h22, 8'h33, 8'h44, 32'd2900));
		send_request(frame_req(RST_STRIP_BASE - 29'd1, 4'd8, 8'h11, 8'h22, 8'h33, 8'h44,
			32'd2900));
		send_request(frame_req(ID_MAX, 4'd8, 8'h11, 8'h22, 8'h33, 8'h44, 32'd2900));
		send_request(strip_query(3'd0, 32'd2999));
		// Age measured across the wrap of the millisecond counter.
		send_request(frame_req(RST_STRIP_BASE + 29'd2, 4'd8, 8'hC0, 8'h40, 8'h08, 8'hFE,
			32'hFFFF_FFFF));
		send_request(strip_query(3'd2, 32'd999));
		drain_pipeline();
	endtask

	// Overlapping identifiers and the extremes of every register.
	task automatic test_register_extremes();
		set_registers(32'(RST_STRIP_BASE) + 32'd3, 32'(RST_STRIP_BASE), 32'd1000, 32'h80);
		send_request(frame_req(RST_STRIP_BASE + 29'd3, 4'd1, 8'h80, 8'h01, 8'h02, 8'h03, 32'd3050));
		send_request(strip_query(3'd3, 32'd3100));
		send_request(park_query(32'd3060));
		// Zero timeout: everything is offline.
		set_registers(32'(RST_STRIP_BASE) + 32'd3, 32'(RST_STRIP_BASE), 32'd0, 32'hFF);
		send_request(park_query(32'd3060));
		send_request(strip_query(3'd3, 32'd3100));
		// Upper bits of the identifier writes are dropped; mask zero hides park.
		set_registers(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
		send_request(frame_req('0, 4'd8, 8'hFF, 8'h00, 8'h00, 8'h00, 32'd50));
		send_request(park_query(32'd60));
		send_request(frame_req(ID_MAX, 4'd8, 8'hFF, 8'h80, 8'h40, 8'hFF, 32'd70));
		send_request(strip_query(3'd0, 32'd70));
		send_request(strip_query(3'd0, 32'd69));
		send_request(frame_req(29'd1, 4'd8, 8'h01, 8'h01, 8'h01, 8'h01, 32'd70));
		// Timeout of one: only the stamp time itself is fresh.
		set_registers(32'(ID_MAX), 32'd0, 32'd1, 32'h1);
		send_request(frame_req(ID_MAX, 4'd1, 8'h01, 8'h00, 8'h00, 8'h00, 32'd80));
		send_request(park_query(32'd80));
		send_request(park_query(32'd81));
		send_request(frame_req(29'd7, 4'd8, 8'hAA, 8'h55, 8'hFF, 8'h7F, 32'd90));
		send_request(strip_query(3'd7, 32'd90));
		send_request(strip_query(3'd7, 32'd91));
		drain_pipeline();
	endtask

	// Random traffic over several register settings; one phase runs without gaps.
	task automatic test_random_traffic();
		logic [31:0] sig;
		logic [31:0] base;
		logic [31:0] tmo;
		logic [31:0] mask;
		for (int p = 0; p < PHASES; p++) begin
			case ($urandom_range(0, 4))
				0: base = 32'd0;
				1: base = 32'(ID_MAX) - $urandom_range(0, STRIPS - 1);
				default: base = $urandom_range(0, 32'(ID_MAX));
			endcase
			case ($urandom_range(0, 4))
				0: sig = 32'd0;
				1: sig = 32'(ID_MAX);
				2: sig = 32'(ID_W'(base + $urandom_range(0, STRIPS - 1)));
				default: sig = $urandom_range(0, 32'(ID_MAX));
			endcase
			case ($urandom_range(0, 5))
				0: tmo = 32'd0;
				1: tmo = 32'd1;
				2: tmo = 32'hFFFF_FFFF;
				3: tmo = $urandom_range(2, 64);
				default: tmo = $urandom_range(100, 20000);
			endcase
			case ($urandom_range(0, 3))
				0: mask = 32'h00;
				1: mask = 32'hFF;
				2: mask = 32'h1 << $urandom_range(0, 7);
				default: mask = $urandom_range(0, 255);
			endcase
			if (p == 0)
				set_registers(32'(RST_SIGNAL_ID), 32'(RST_STRIP_BASE), RST_TIMEOUT, 32'(RST_PARK_MASK));
			else
				set_registers(sig, base, tmo, mask);
			idle_pct = (p == 2) ? 0 : IDLE_PCT;
			clock_ms = (p % 2 == 1) ? 32'hFFFF_F000 + $urandom_range(0, 32'hFFF)
				: $urandom_range(1, 5000);
			repeat (PHASE_BEATS) send_request(next_traffic());
		end
		idle_pct = IDLE_PCT;
		drain_pipeline();
	endtask

	// Compares each result beat with the oldest expected status.
	always @(posedge clk) begin : check_result
		status_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_status_q.size() == 0) begin
				$error("result beat with no request outstanding");
				error_count++;
			end else begin
				want = pending_status_q.pop_front();
				results_checked++;
				if (frame_taken !== want.taken) begin
					$error("frame_taken: expected %0d, got %0d", want.taken, frame_taken);
					error_count++;
				end
				if (strip_online !== want.online) begin
					$error("strip_online: expected %0d, got %0d", want.online, strip_online);
					error_count++;
				end
				if (strip_color !== want.color) begin
					$error("strip_color: expected %06h, got %06h", want.color, strip_color);
					error_count++;
				end
				if (park_on !== want.park) begin
					$error("park_on: expected %0d, got %0d", want.park, park_on);
					error_count++;
				end
			end
		end
	end

	// Ends the run if neither side moves a beat for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done === 1'b1) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat moved in %0d cycles", STALL_LIMIT);
			$display("tb_can_light_status_table_unit: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		for (int k = 0; k < STRIPS; k++) begin
			red_tbl[k] = '0;
			green_tbl[k] = '0;
			blue_tbl[k] = '0;
			scale_tbl[k] = '0;
			stamp_tbl[k] = '0;
		end
		light_byte = '0;
		light_stamp = '0;
		clock_ms = '0;
		cfg_now = '{RST_SIGNAL_ID, RST_STRIP_BASE, RST_TIMEOUT, RST_PARK_MASK};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_register_extremes();
		test_random_traffic();
		$display("covered %0d requests under %0d register settings plus the reset values",
			beats_sent, settings_used);
		$display("checked %0d result beats, %0d mismatches", results_checked, error_count);
		if (error_count == 0)
			$display("tb_can_light_status_table_unit: done, clean");
		else
			$display("tb_can_light_status_table_unit: done, errors");
		$finish;
	end

endmodule
